// File: sv/pqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqe_pkg;

    // Sizes of the codebook and of the fields
    localparam int MAX_SUBSPACES = 8;
    localparam int MAX_CODEWORDS = 256;
    localparam int MAX_SUBVECTOR = 8;

    localparam int SUB_W     = 3;   // subspace index
    localparam int CW_W      = 8;   // codeword index
    localparam int ELEM_W    = 3;   // element within a subvector
    localparam int SAMPLE_W  = 16;  // Q8.8 value
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int SQ_W      = 32;  // square of a 17-bit difference always fits
    localparam int DIST_W    = 35;  // Q19.16 distance
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam int CB_ADDR_W = SUB_W + CW_W + ELEM_W;
    localparam int CB_DEPTH  = MAX_SUBSPACES * MAX_CODEWORDS * MAX_SUBVECTOR;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUBVECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSPACE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODEWORD_BITS    = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SUBVECTOR_LENGTH = 4'd4;
    localparam logic [CFG_W-1:0] RST_SUBSPACE_COUNT   = 4'd8;
    localparam logic [CFG_W-1:0] RST_CODEWORD_BITS    = 4'd8;

    // Operation codes on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } pqe_state_t;

    // One codeword step handed to the distance unit
    typedef struct packed {
        logic            valid;
        logic            first;   // first element of the subvector: start from zero
        logic [CW_W-1:0] k;
    } pqe_issue_t;

endpackage

`default_nettype wire

// File: sv/pqe_codebook.sv
`timescale 1ns / 1ps
`default_nettype none

module pqe_codebook (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [pqe_pkg::CB_ADDR_W-1:0]  wr_addr,
    input  wire logic [pqe_pkg::SAMPLE_W-1:0]   wr_data,
    input  wire logic                           rd_en,
    input  wire logic [pqe_pkg::CB_ADDR_W-1:0]  rd_addr,
    output logic      [pqe_pkg::SAMPLE_W-1:0]   rd_data
);
    import pqe_pkg::*;

    logic [SAMPLE_W-1:0] mem [CB_DEPTH];

    // Load port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read for the sweep
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/pqe_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module pqe_dist_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pqe_pkg::pqe_issue_t           issue,
    input  wire logic [pqe_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [pqe_pkg::SAMPLE_W-1:0]  cb_rdata,
    output logic                               busy,
    output logic      [pqe_pkg::DIST_W-1:0]    best_dist,
    output logic      [pqe_pkg::CW_W-1:0]      best_code
);
    import pqe_pkg::*;

    // Partial distance per codeword
    logic [DIST_W-1:0] pd_mem [MAX_CODEWORDS];
    logic [DIST_W-1:0] pd_rdata_reg;

    // Stage 1: codebook and partial distance data arrive
    logic            st1_valid_reg;
    logic            st1_first_reg;
    logic [CW_W-1:0] st1_k_reg;

    // Stage 2: square registered, accumulate and compare
    logic              st2_valid_reg;
    logic [CW_W-1:0]   st2_k_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [DIST_W-1:0] base_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    logic [DIST_W:0]            sum;
    logic [DIST_W-1:0]          acc;

    logic [DIST_W-1:0] best_dist_reg;
    logic [CW_W-1:0]   best_code_reg;

    // Partial distance read, registered
    always_ff @(posedge aclk) begin
        if (issue.valid) begin
            pd_rdata_reg <= pd_mem[issue.k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= issue.valid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        st1_first_reg <= issue.first;
        st1_k_reg     <= issue.k;
    end

    // Difference and square
    assign diff = $signed({sample[SAMPLE_W-1], sample})
                - $signed({cb_rdata[SAMPLE_W-1], cb_rdata});
    assign prod = diff * diff;

    always_ff @(posedge aclk) begin
        st2_k_reg <= st1_k_reg;
        sq_reg    <= prod[SQ_W-1:0];
        base_reg  <= st1_first_reg ? '0 : pd_rdata_reg;
    end

    // Saturating accumulate
    assign sum = {1'b0, base_reg} + (DIST_W + 1)'(sq_reg);
    assign acc = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (st2_valid_reg) begin
            pd_mem[st2_k_reg] <= acc;
        end
    end

    // Running minimum, strict less keeps the lowest index on a tie
    always_ff @(posedge aclk) begin
        if (st2_valid_reg && ((st2_k_reg == '0) || (acc < best_dist_reg))) begin
            best_dist_reg <= acc;
            best_code_reg <= st2_k_reg;
        end
    end

    assign busy      = st1_valid_reg | st2_valid_reg;
    assign best_dist = best_dist_reg;
    assign best_code = best_code_reg;

endmodule

`default_nettype wire

// File: sv/product_quantizer_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Product quantization encoder. Requests with s_tuser = 0 load one codebook
// element (subspace, codeword, element, Q8.8 value). Requests with s_tuser = 1
// carry the next element of a vector; a single subtract/square/accumulate
// unit then sweeps all 2^codeword_bits codewords, one per cycle, and no new
// request is taken until that sweep has drained from the unit's pipeline.
// After the last element of a subvector the nearest codeword (lowest index on
// a tie) and its Q19.16 squared distance go out on m_*, m_tlast marking the
// final subspace of the vector; the result waits while a previous result is
// still held on the output. Any write to one of the three defined registers
// restarts the vector. Codebook entries must be loaded before they are used.
module product_quantizer_encoder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pqe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pqe_pkg::CFG_W-1:0]           cfg_data,

    // Input requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [2:0] load_subspace, [10:3] load_codeword, [13:11] load_element,
    // [29:14] sample_value, [31:30] zero
    input  wire logic [pqe_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [0] operation
    input  wire logic                                s_tuser,

    // Results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] subspace_index, [10:3] code, [45:11] best_distance, [47:46] zero
    output logic      [pqe_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                     m_tlast
);
    import pqe_pkg::*;

    // Clamp a register to 1..8
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > 4'd8) begin
            r = 4'd8;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Input field unpacking
    logic [SUB_W-1:0]    in_subspace;
    logic [CW_W-1:0]     in_codeword;
    logic [ELEM_W-1:0]   in_element;
    logic [SAMPLE_W-1:0] in_sample;

    assign in_subspace = s_tdata[2:0];
    assign in_codeword = s_tdata[10:3];
    assign in_element  = s_tdata[13:11];
    assign in_sample   = s_tdata[29:14];

    // Configuration registers
    logic [CFG_W-1:0] sub_len_reg;
    logic [CFG_W-1:0] sub_count_reg;
    logic [CFG_W-1:0] cw_bits_reg;
    logic             cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_SUBVECTOR_LENGTH) ||
                                     (cfg_index == REG_SUBSPACE_COUNT) ||
                                     (cfg_index == REG_CODEWORD_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_len_reg   <= RST_SUBVECTOR_LENGTH;
            sub_count_reg <= RST_SUBSPACE_COUNT;
            cw_bits_reg   <= RST_CODEWORD_BITS;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SUBVECTOR_LENGTH: sub_len_reg   <= cfg_data;
                REG_SUBSPACE_COUNT:   sub_count_reg <= cfg_data;
                REG_CODEWORD_BITS:    cw_bits_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective settings
    logic [CFG_W-1:0] len_eff;
    logic [CFG_W-1:0] subs_eff;
    logic [CFG_W-1:0] cwb_eff;
    logic [CW_W:0]    ncw;
    logic [CW_W-1:0]  last_k;

    assign len_eff  = clamp_cfg(sub_len_reg);
    assign subs_eff = clamp_cfg(sub_count_reg);
    assign cwb_eff  = clamp_cfg(cw_bits_reg);
    assign ncw      = (CW_W + 1)'(1) << cwb_eff;
    assign last_k   = CW_W'(ncw - (CW_W + 1)'(1));

    // Sequencer state
    pqe_state_t state_reg, state_next;

    logic [ELEM_W-1:0]   elem_pos_reg;
    logic [SUB_W-1:0]    sub_pos_reg;
    logic [CW_W-1:0]     k_reg;
    logic [SAMPLE_W-1:0] x_reg;

    logic s_accept;
    logic vec_accept;
    logic load_accept;
    logic unit_busy;
    logic more_elems;
    logic last_sub;
    logic out_free;

    assign s_accept    = s_tvalid && s_tready;
    assign vec_accept  = s_accept && (s_tuser == OP_VECTOR);
    assign load_accept = s_accept && (s_tuser == OP_LOAD);
    assign more_elems  = ({1'b0, elem_pos_reg} + 4'd1) < len_eff;
    assign last_sub    = ({1'b0, sub_pos_reg} + 4'd1) >= subs_eff;
    assign out_free    = !m_tvalid || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (vec_accept) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (k_reg == last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!unit_busy) begin
                    state_next = more_elems ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    pqe_issue_t issue;
    logic       emit;

    always_comb begin
        s_tready    = 1'b0;
        issue.valid = 1'b0;
        issue.first = (elem_pos_reg == '0);
        issue.k     = k_reg;
        emit        = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready    = 1'b1;
            ST_SWEEP: issue.valid = 1'b1;
            ST_DRAIN: ;
            ST_EMIT:  emit        = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Positions and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_pos_reg <= '0;
            sub_pos_reg  <= '0;
            k_reg        <= '0;
        end else if (cfg_hit) begin
            elem_pos_reg <= '0;
            sub_pos_reg  <= '0;
        end else begin
            if (vec_accept) begin
                k_reg <= '0;
                if ({1'b0, elem_pos_reg} >= len_eff) begin
                    elem_pos_reg <= '0;
                end
                if ({1'b0, sub_pos_reg} >= subs_eff) begin
                    sub_pos_reg <= '0;
                end
            end
            if (issue.valid) begin
                k_reg <= k_reg + CW_W'(1);
            end
            if ((state_reg == ST_DRAIN) && !unit_busy && more_elems) begin
                elem_pos_reg <= elem_pos_reg + ELEM_W'(1);
            end
            if (emit) begin
                elem_pos_reg <= '0;
                sub_pos_reg  <= last_sub ? '0 : sub_pos_reg + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (vec_accept) begin
            x_reg <= in_sample;
        end
    end

    // Codebook store
    logic [SAMPLE_W-1:0] cb_rdata;

    pqe_codebook u_codebook (
        .aclk    (aclk),
        .wr_en   (load_accept),
        .wr_addr ({in_subspace, in_codeword, in_element}),
        .wr_data (in_sample),
        .rd_en   (issue.valid),
        .rd_addr ({sub_pos_reg, k_reg, elem_pos_reg}),
        .rd_data (cb_rdata)
    );

    // Shared square-accumulate and minimum unit
    logic [DIST_W-1:0] best_dist;
    logic [CW_W-1:0]   best_code;

    pqe_dist_unit u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .sample    (x_reg),
        .cb_rdata  (cb_rdata),
        .busy      (unit_busy),
        .best_dist (best_dist),
        .best_code (best_code)
    );

    // Output register
    logic              m_valid_reg;
    logic [SUB_W-1:0]  out_sub_reg;
    logic [CW_W-1:0]   out_code_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_sub_reg  <= sub_pos_reg;
            out_code_reg <= best_code;
            out_dist_reg <= best_dist;
            out_last_reg <= last_sub;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_dist_reg, out_code_reg, out_sub_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
